// ----- src/float_exponential_unit_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the exponential unit
// Concurrent checks that vanish from synthesis builds.
// ----------------------------------------------------------------------------
`ifndef FLOAT_EXPONENTIAL_UNIT_ASSERT_SVH
`define FLOAT_EXPONENTIAL_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define FEU_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("%m: check failed");
`define FEU_ASSERT_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("%m: forbidden condition seen");
`else
`define FEU_ASSERT(lbl, clk, rst_n, prop)
`define FEU_ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif

`endif

// ----- src/feu_pkg.sv -----
// ----------------------------------------------------------------------------
// Exponential unit package
// Single-precision constants and round-to-nearest-even arithmetic helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package feu_pkg;

	localparam logic [31:0] HI_LIMIT  = 32'h42B0_0000;  // 88.0
	localparam logic [31:0] INV_LN2   = 32'h3FB8_AA3B;
	localparam logic [31:0] LN2       = 32'h3F31_7218;
	localparam logic [31:0] ONE       = 32'h3F80_0000;
	localparam logic [31:0] HALF      = 32'h3F00_0000;
	localparam logic [31:0] C3        = 32'h3E2A_AAAA;
	localparam logic [31:0] C4        = 32'h3D2A_AAA9;
	localparam logic [31:0] C5        = 32'h3C08_8885;
	localparam logic [31:0] C6        = 32'h3AB6_0B6A;
	localparam logic [31:0] FMAX_BITS = 32'h7F7F_FFFF;
	localparam logic [31:0] ZERO_BITS = 32'h0000_0000;
	localparam logic [31:0] QNAN      = 32'h7FC0_0000;
	localparam logic [31:0] QUIET_BIT = 32'h0040_0000;
	localparam logic [7:0]  BIAS      = 8'd127;
	localparam int          LATENCY   = 13;

	localparam logic [1:0] CLAMP_NONE = 2'd0;
	localparam logic [1:0] CLAMP_HIGH = 2'd1;
	localparam logic [1:0] CLAMP_LOW  = 2'd2;

	typedef struct packed {
		logic        special;
		logic [31:0] ysp;
		logic [1:0]  code;
	} feu_side_t;

	function automatic logic [6:0] lzc64(input logic [63:0] v);
		logic [6:0] n;
		logic       found;
		n = 7'd64;
		found = 1'b0;
		for (int i = 63; i >= 0; i--) begin
			if (!found && v[i]) begin
				n = 7'(63 - i);
				found = 1'b1;
			end
		end
		return n;
	endfunction

	// m has its leading one at bit 47 (or is zero); e is the biased exponent
	function automatic logic [31:0] round_pack(input logic s, input logic signed [11:0] e,
			input logic [47:0] m);
		logic [47:0] m2;
		logic [5:0]  sh;
		logic        lost;
		logic [7:0]  ef;
		logic [30:0] base;
		logic        g;
		logic        st;
		logic        inc;
		if (m == 48'd0)
			return {s, 31'd0};
		if (e > 12'sd254)
			return {s, 8'hFF, 23'd0};
		if (e < 12'sd1) begin
			sh = (e < -12'sd46) ? 6'd48 : 6'(12'sd1 - e);
			m2 = m >> sh;
			lost = ((m2 << sh) != m);
			ef = 8'd0;
		end else begin
			sh = 6'd0;
			m2 = m;
			lost = 1'b0;
			ef = e[7:0];
		end
		base = {ef, m2[46:24]};
		g = m2[23];
		st = (|m2[22:0]) | lost | (sh == 6'd63);
		inc = g & (st | m2[24]);
		return {s, base + 31'(inc)};
	endfunction

	function automatic logic [31:0] fmul(input logic [31:0] a, input logic [31:0] b);
		logic               s;
		logic [7:0]         ea;
		logic [7:0]         eb;
		logic [23:0]        ma;
		logic [23:0]        mb;
		logic [47:0]        p;
		logic [6:0]         lz;
		logic [63:0]        nrm;
		logic signed [11:0] e;
		logic               na, nb, ia, ib, za, zb;
		s  = a[31] ^ b[31];
		na = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
		nb = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
		ia = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
		ib = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
		za = (a[30:0] == 31'd0);
		zb = (b[30:0] == 31'd0);
		if (na || nb)
			return QNAN;
		if (ia || ib)
			return (za || zb) ? QNAN : {s, 8'hFF, 23'd0};
		if (za || zb)
			return {s, 31'd0};
		ea = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
		eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
		ma = {a[30:23] != 8'd0, a[22:0]};
		mb = {b[30:23] != 8'd0, b[22:0]};
		p = ma * mb;
		lz = lzc64({p, 16'd0});
		nrm = {p, 16'd0} << lz;
		e = $signed({4'd0, ea} + {4'd0, eb} - 12'd126 - {5'd0, lz});
		return round_pack(s, e, nrm[63:16]);
	endfunction

	function automatic logic [31:0] fadd(input logic [31:0] a, input logic [31:0] b);
		logic [31:0]        bg;
		logic [31:0]        sm;
		logic [7:0]         ex;
		logic [7:0]         ey;
		logic [7:0]         d;
		logic [5:0]         sh;
		logic [48:0]        a49;
		logic [48:0]        b49;
		logic [48:0]        bs;
		logic [48:0]        sum;
		logic               lost;
		logic [6:0]         lz;
		logic [63:0]        nrm;
		logic signed [11:0] e;
		logic               na, nb, ia, ib;
		na = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
		nb = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
		ia = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
		ib = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
		if (na || nb)
			return QNAN;
		if (ia && ib)
			return (a[31] != b[31]) ? QNAN : a;
		if (ia)
			return a;
		if (ib)
			return b;
		if (a[30:0] == 31'd0 && b[30:0] == 31'd0)
			return {a[31] & b[31], 31'd0};
		if (a[30:0] == 31'd0)
			return b;
		if (b[30:0] == 31'd0)
			return a;
		if (a[30:0] < b[30:0]) begin
			bg = b;
			sm = a;
		end else begin
			bg = a;
			sm = b;
		end
		ex = (bg[30:23] == 8'd0) ? 8'd1 : bg[30:23];
		ey = (sm[30:23] == 8'd0) ? 8'd1 : sm[30:23];
		d = ex - ey;
		sh = (d > 8'd63) ? 6'd63 : d[5:0];
		a49 = {1'b0, bg[30:23] != 8'd0, bg[22:0], 24'd0};
		b49 = {1'b0, sm[30:23] != 8'd0, sm[22:0], 24'd0};
		bs = b49 >> sh;
		lost = ((bs << sh) != b49);
		bs[0] = bs[0] | lost;
		sum = (bg[31] == sm[31]) ? (a49 + bs) : (a49 - bs);
		if (sum == 49'd0)
			return ZERO_BITS;
		lz = lzc64({sum, 15'd0});
		nrm = {sum, 15'd0} << lz;
		e = $signed({4'd0, ex} + 12'd1 - {5'd0, lz});
		return round_pack(bg[31], e, {nrm[63:17], |nrm[16:0]});
	endfunction

	// floor of a value known to be well inside +-128
	function automatic logic signed [8:0] floor_small(input logic [31:0] t);
		logic [7:0]         e;
		logic [23:0]        mant;
		logic [4:0]         sh;
		logic [4:0]         rs;
		logic [7:0]         mag;
		logic [23:0]        fmask;
		logic               fnz;
		logic signed [8:0]  n;
		e = t[30:23];
		mant = {1'b1, t[22:0]};
		if (e < BIAS) begin
			mag = 8'd0;
			fnz = |t[30:0];
		end else begin
			sh = (e > 8'd134) ? 5'd7 : 5'(e - BIAS);
			rs = 5'd23 - sh;
			mag = 8'(mant >> rs);
			fmask = (24'd1 << rs) - 24'd1;
			fnz = |(mant & fmask);
		end
		n = t[31] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
		if (t[31] && fnz)
			n = n - 9'sd1;
		return n;
	endfunction

	function automatic logic [31:0] int_to_float(input logic signed [8:0] n);
		logic       s;
		logic [7:0] mag;
		logic [2:0] lz;
		logic [7:0] nm;
		logic       found;
		if (n == 9'sd0)
			return ZERO_BITS;
		s = n[8];
		mag = 8'(s ? -n : n);
		lz = 3'd0;
		found = 1'b0;
		for (int i = 7; i >= 0; i--) begin
			if (!found && mag[i]) begin
				lz = 3'(7 - i);
				found = 1'b1;
			end
		end
		nm = mag << lz;
		return {s, 8'd134 - {5'd0, lz}, nm[6:0], 16'd0};
	endfunction

endpackage

`default_nettype wire

// ----- src/feu_reduce.sv -----
// ----------------------------------------------------------------------------
// Range reduction
// Stages 1 to 5: n = floor(x/ln2 + 0.5), r = x - n*ln2, special-case sort.
// ----------------------------------------------------------------------------
`default_nettype none

module feu_reduce (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_vld,
	input  logic [31:0]         x,
	output logic                out_vld,
	output logic [31:0]         r,
	output logic signed [8:0]   n,
	output feu_pkg::feu_side_t  side
);
	import feu_pkg::*;

	logic               is_nan;
	feu_side_t          side_in;

	logic               vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic [31:0]        x_s1, x_s2, x_s3, x_s4;
	logic [31:0]        t_s1, t_s2;
	logic [31:0]        nf_s3, nl_s4, r_s5;
	logic signed [8:0]  n_s3, n_s4, n_s5;
	feu_side_t          side_s1, side_s2, side_s3, side_s4, side_s5;

	always_comb begin
		is_nan = (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
		side_in.special = 1'b1;
		side_in.ysp = x | QUIET_BIT;
		side_in.code = CLAMP_NONE;
		if (!is_nan) begin
			if (!x[31] && x[30:0] > HI_LIMIT[30:0]) begin
				side_in.ysp = FMAX_BITS;
				side_in.code = CLAMP_HIGH;
			end else if (x[31] && x[30:0] > HI_LIMIT[30:0]) begin
				side_in.ysp = ZERO_BITS;
				side_in.code = CLAMP_LOW;
			end else begin
				side_in.special = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		x_s1    <= x;
		t_s1    <= fmul(x, INV_LN2);
		side_s1 <= side_in;

		x_s2    <= x_s1;
		t_s2    <= fadd(t_s1, HALF);
		side_s2 <= side_s1;

		x_s3    <= x_s2;
		n_s3    <= floor_small(t_s2);
		nf_s3   <= int_to_float(floor_small(t_s2));
		side_s3 <= side_s2;

		x_s4    <= x_s3;
		n_s4    <= n_s3;
		nl_s4   <= fmul(nf_s3, LN2);
		side_s4 <= side_s3;

		// subtract by flipping the sign of n*ln2
		r_s5    <= fadd(x_s4, {~nl_s4[31], nl_s4[30:0]});
		n_s5    <= n_s4;
		side_s5 <= side_s4;
	end

	assign out_vld = vld_s5;
	assign r       = r_s5;
	assign n       = n_s5;
	assign side    = side_s5;

endmodule

`default_nettype wire

// ----- src/feu_poly.sv -----
// ----------------------------------------------------------------------------
// Taylor polynomial
// Stages 6 to 12: powers of r, weighted terms and the left-to-right sum.
// ----------------------------------------------------------------------------
`default_nettype none

module feu_poly (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_vld,
	input  logic [31:0]         r,
	input  logic signed [8:0]   n,
	input  feu_pkg::feu_side_t  side,
	output logic                out_vld,
	output logic [31:0]         sum,
	output logic signed [8:0]   n_out,
	output feu_pkg::feu_side_t  side_out
);
	import feu_pkg::*;

	logic               vld_s6, vld_s7, vld_s8, vld_s9, vld_s10, vld_s11, vld_s12;
	logic [31:0]        r_s6, r_s7;
	logic [31:0]        r2_s6, r3_s7, r4_s7, r4_s8, r5_s8, r6_s8;
	logic [31:0]        p2_s7, p3_s8, p4_s9, p5_s9, p5_s10, p6_s9, p6_s10, p6_s11;
	logic [31:0]        s_s6, s_s7, s_s8, s_s9, s_s10, s_s11, s_s12;
	logic signed [8:0]  n_s6, n_s7, n_s8, n_s9, n_s10, n_s11, n_s12;
	feu_side_t          side_s6, side_s7, side_s8, side_s9, side_s10, side_s11, side_s12;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6  <= 1'b0;
			vld_s7  <= 1'b0;
			vld_s8  <= 1'b0;
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
			vld_s11 <= 1'b0;
			vld_s12 <= 1'b0;
		end else begin
			vld_s6  <= in_vld;
			vld_s7  <= vld_s6;
			vld_s8  <= vld_s7;
			vld_s9  <= vld_s8;
			vld_s10 <= vld_s9;
			vld_s11 <= vld_s10;
			vld_s12 <= vld_s11;
		end
	end

	always_ff @(posedge clk) begin
		r_s6     <= r;
		r2_s6    <= fmul(r, r);
		s_s6     <= fadd(ONE, r);
		n_s6     <= n;
		side_s6  <= side;

		r_s7     <= r_s6;
		r3_s7    <= fmul(r2_s6, r_s6);
		r4_s7    <= fmul(r2_s6, r2_s6);
		p2_s7    <= fmul(r2_s6, HALF);
		s_s7     <= s_s6;
		n_s7     <= n_s6;
		side_s7  <= side_s6;

		r4_s8    <= r4_s7;
		r5_s8    <= fmul(r4_s7, r_s7);
		r6_s8    <= fmul(r3_s7, r3_s7);
		p3_s8    <= fmul(r3_s7, C3);
		s_s8     <= fadd(s_s7, p2_s7);
		n_s8     <= n_s7;
		side_s8  <= side_s7;

		p4_s9    <= fmul(r4_s8, C4);
		p5_s9    <= fmul(r5_s8, C5);
		p6_s9    <= fmul(r6_s8, C6);
		s_s9     <= fadd(s_s8, p3_s8);
		n_s9     <= n_s8;
		side_s9  <= side_s8;

		p5_s10   <= p5_s9;
		p6_s10   <= p6_s9;
		s_s10    <= fadd(s_s9, p4_s9);
		n_s10    <= n_s9;
		side_s10 <= side_s9;

		p6_s11   <= p6_s10;
		s_s11    <= fadd(s_s10, p5_s10);
		n_s11    <= n_s10;
		side_s11 <= side_s10;

		s_s12    <= fadd(s_s11, p6_s11);
		n_s12    <= n_s11;
		side_s12 <= side_s11;
	end

	assign out_vld  = vld_s12;
	assign sum      = s_s12;
	assign n_out    = n_s12;
	assign side_out = side_s12;

endmodule

`default_nettype wire

// ----- src/float_exponential_unit.sv -----
// ----------------------------------------------------------------------------
// Single-precision exponential unit
// e to the x by range reduction, a degree-6 Taylor sum and a 2^n scale.
// ----------------------------------------------------------------------------
// Each word passes the reduce, polynomial and scale stages in order; done comes with its result.
// Throughput: one word per cycle; busy is always low, the pipeline never waits.
// Thirteen register stages, each holding about one float multiply or add.
// Reset clears all stage valid bits at once; no words are in flight after it.
`default_nettype none
`include "float_exponential_unit_assert.svh"

module float_exponential_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] x_bits,
	output logic        done,
	output logic [31:0] y_bits,
	output logic [1:0]  clamp_code
);
	import feu_pkg::*;

	logic               red_vld;
	logic [31:0]        red_r;
	logic signed [8:0]  red_n;
	feu_side_t          red_side;

	logic               poly_vld;
	logic [31:0]        poly_sum;
	logic signed [8:0]  poly_n;
	feu_side_t          poly_side;

	logic [31:0]        scale;
	logic               vld_s13;
	logic [31:0]        y_s13;
	logic [1:0]         code_s13;

	feu_reduce u_reduce (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (start),
		.x       (x_bits),
		.out_vld (red_vld),
		.r       (red_r),
		.n       (red_n),
		.side    (red_side)
	);

	feu_poly u_poly (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (red_vld),
		.r        (red_r),
		.n        (red_n),
		.side     (red_side),
		.out_vld  (poly_vld),
		.sum      (poly_sum),
		.n_out    (poly_n),
		.side_out (poly_side)
	);

	// build 2^n straight in the exponent field
	assign scale = {1'b0, 8'(9'(BIAS) + poly_n), 23'd0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s13 <= 1'b0;
		else
			vld_s13 <= poly_vld;
	end

	always_ff @(posedge clk) begin
		y_s13    <= poly_side.special ? poly_side.ysp : fmul(poly_sum, scale);
		code_s13 <= poly_side.code;
	end

	assign busy       = 1'b0;
	assign done       = vld_s13;
	assign y_bits     = y_s13;
	assign clamp_code = code_s13;

	`FEU_ASSERT(a_latency, clk, arst_n, start |-> ##LATENCY done)
	`FEU_ASSERT(a_clamp_high, clk, arst_n, done && clamp_code == CLAMP_HIGH |-> y_bits == FMAX_BITS)
	`FEU_ASSERT(a_clamp_low, clk, arst_n, done && clamp_code == CLAMP_LOW |-> y_bits == ZERO_BITS)
	`FEU_ASSERT_NEVER(a_code, clk, arst_n, done && clamp_code > CLAMP_LOW)

endmodule

`default_nettype wire

// ----- tb/exp_checker.sv -----
// ----------------------------------------------------------------------------
// Exponential unit checker
// Watches the command and result channels, predicts e to the x for every
// accepted word with its own single-precision arithmetic and compares results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module exp_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [31:0] x_bits,
	input  logic        done,
	input  logic [31:0] y_bits,
	input  logic [1:0]  clamp_code,
	output int          errors,
	output int          pending
);
	import feu_pkg::*;

	typedef struct packed {
		logic [31:0] y;
		logic [1:0]  code;
	} exp_result_t;

	exp_result_t exp_queue[$];

	function automatic void sp_unpack(input logic [31:0] f, output logic [23:0] m,
			output int e);
		if (f[30:23] == 8'd0) begin
			m = {1'b0, f[22:0]};
			e = -149;
		end else begin
			m = {1'b1, f[22:0]};
			e = int'(f[30:23]) - 150;
		end
	endfunction

	// round the exact value m * 2^e2 (m nonzero) to single, nearest even
	function automatic logic [31:0] sp_round(input logic s, input int e2,
			input logic [127:0] m);
		logic [255:0] w;
		logic [255:0] mant;
		logic         guard;
		logic         sticky;
		int           k;
		int           sh;
		int           lsb_e;
		int           be;
		w = {128'd0, m};
		k = 0;
		for (int i = 0; i < 128; i++)
			if (m[i])
				k = i;
		sh = k - 23;
		if (-149 - e2 > sh)
			sh = -149 - e2;
		if (sh > 255)
			sh = 255;
		if (sh <= 0) begin
			mant = w << (-sh);
		end else begin
			guard = w[sh - 1];
			sticky = |(w & ((256'd1 << (sh - 1)) - 256'd1));
			mant = w >> sh;
			if (guard && (sticky || mant[0]))
				mant = mant + 256'd1;
		end
		lsb_e = e2 + sh;
		if (mant[24]) begin
			mant = mant >> 1;
			lsb_e++;
		end
		if (!mant[23])
			return {s, 8'd0, mant[22:0]};
		be = lsb_e + 150;
		if (be >= 255)
			return {s, 8'hFF, 23'd0};
		return {s, be[7:0], mant[22:0]};
	endfunction

	function automatic logic [31:0] sp_mul(input logic [31:0] a, input logic [31:0] b);
		logic [23:0] ma;
		logic [23:0] mb;
		int          ea;
		int          eb;
		if (a[30:0] == 31'd0 || b[30:0] == 31'd0)
			return {a[31] ^ b[31], 31'd0};
		sp_unpack(a, ma, ea);
		sp_unpack(b, mb, eb);
		return sp_round(a[31] ^ b[31], ea + eb, 128'(ma) * 128'(mb));
	endfunction

	function automatic logic [127:0] align_mant(input logic [23:0] m, input int d);
		logic [127:0] v;
		if (d >= 0)
			return 128'(m) << d;
		if (d <= -24)
			return 128'd1;
		v = 128'(m) >> (-d);
		if ((v << (-d)) != 128'(m))
			v[0] = 1'b1;
		return v;
	endfunction

	function automatic logic [31:0] sp_add(input logic [31:0] a, input logic [31:0] b);
		logic [23:0]  ma;
		logic [23:0]  mb;
		logic [127:0] wa;
		logic [127:0] wb;
		logic [127:0] wr;
		logic         sr;
		int           ea;
		int           eb;
		int           base;
		if (a[30:0] == 31'd0 && b[30:0] == 31'd0)
			return {a[31] & b[31], 31'd0};
		if (a[30:0] == 31'd0)
			return b;
		if (b[30:0] == 31'd0)
			return a;
		sp_unpack(a, ma, ea);
		sp_unpack(b, mb, eb);
		base = ((ea > eb) ? ea : eb) - 100;
		wa = align_mant(ma, ea - base);
		wb = align_mant(mb, eb - base);
		if (a[31] == b[31]) begin
			wr = wa + wb;
			sr = a[31];
		end else if (wa >= wb) begin
			wr = wa - wb;
			sr = a[31];
		end else begin
			wr = wb - wa;
			sr = b[31];
		end
		if (wr == 128'd0)
			return 32'd0;
		return sp_round(sr, base, wr);
	endfunction

	// truncate toward zero, then step down for negative non-integers
	function automatic int sp_floor(input logic [31:0] t);
		logic [23:0] m;
		int          e;
		int          mag;
		logic        frac;
		if (t[30:0] == 31'd0)
			return 0;
		sp_unpack(t, m, e);
		if (e >= 0) begin
			mag = int'(m) << e;
			frac = 1'b0;
		end else if (e <= -32) begin
			mag = 0;
			frac = 1'b1;
		end else begin
			mag = int'(m) >> (-e);
			frac = ((m & ((24'd1 << (-e)) - 24'd1)) != 24'd0) || (-e > 24);
		end
		if (t[31]) begin
			mag = -mag;
			if (frac)
				mag--;
		end
		return mag;
	endfunction

	function automatic exp_result_t predict_exp(input logic [31:0] x);
		exp_result_t res;
		logic [31:0] t, nf, r, r2, r3, r4, r5, r6, s, scale;
		int          n;
		logic [7:0]  field;
		res.code = CLAMP_NONE;
		if (x[30:23] == 8'hFF && x[22:0] != 23'd0) begin
			res.y = x | QUIET_BIT;
		end else if (!x[31] && x[30:0] > HI_LIMIT[30:0]) begin
			res.y = FMAX_BITS;
			res.code = CLAMP_HIGH;
		end else if (x[31] && x[30:0] > HI_LIMIT[30:0]) begin
			res.y = ZERO_BITS;
			res.code = CLAMP_LOW;
		end else begin
			t = sp_add(sp_mul(x, INV_LN2), HALF);
			n = sp_floor(t);
			nf = (n == 0) ? 32'd0 : sp_round(n < 0, 0, 128'((n < 0) ? -n : n));
			r = sp_add(x, sp_mul(nf, LN2) ^ 32'h8000_0000);
			r2 = sp_mul(r, r);
			r3 = sp_mul(r2, r);
			r4 = sp_mul(r2, r2);
			r5 = sp_mul(r4, r);
			r6 = sp_mul(r3, r3);
			s = sp_add(ONE, r);
			s = sp_add(s, sp_mul(r2, HALF));
			s = sp_add(s, sp_mul(r3, C3));
			s = sp_add(s, sp_mul(r4, C4));
			s = sp_add(s, sp_mul(r5, C5));
			s = sp_add(s, sp_mul(r6, C6));
			field = 8'(127 + n);
			scale = {1'b0, field, 23'd0};
			res.y = sp_mul(s, scale);
		end
		return res;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		exp_result_t want;
		if (!arst_n) begin
			errors <= 0;
			pending <= 0;
			exp_queue.delete();
		end else begin
			if (start && !busy)
				exp_queue.push_back(predict_exp(x_bits));
			if (done) begin
				if (exp_queue.size() == 0) begin
					$display("%0t: result word with nothing expected: y=%h code=%0d",
						$time, y_bits, clamp_code);
					errors <= errors + 1;
				end else begin
					want = exp_queue.pop_front();
					if (want.y !== y_bits || want.code !== clamp_code) begin
						$display("%0t: y_bits expected %h actual %h, %s %0d actual %0d",
							$time, want.y, y_bits, "clamp_code expected",
							want.code, clamp_code);
						errors <= errors + 1;
					end
				end
			end
			pending <= exp_queue.size();
		end
	end

endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// Exponential unit testbench
// Directed edge arguments, then random words under three idle patterns;
// the checker predicts and compares, this module gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
	import feu_pkg::*;

	localparam int CYCLE_LIMIT = 200000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic [31:0] x_bits = 32'd0;
	logic        busy;
	logic        done;
	logic [31:0] y_bits;
	logic [1:0]  clamp_code;
	int          errors;
	int          pending;
	int          cycles = 0;

	always #5 clk = ~clk;

	float_exponential_unit DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .x_bits(x_bits),
		.done(done), .y_bits(y_bits), .clamp_code(clamp_code)
	);

	exp_checker checker_i (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .x_bits(x_bits),
		.done(done), .y_bits(y_bits), .clamp_code(clamp_code),
		.errors(errors), .pending(pending)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// hold the word until it is taken
	task automatic send_word(input logic [31:0] v);
		start <= 1'b1;
		x_bits <= v;
		forever begin
			@(negedge clk);
			if (!busy) begin
				@(posedge clk);
				break;
			end
			@(posedge clk);
		end
	endtask

	task automatic idle_cycle();
		start <= 1'b0;
		x_bits <= $urandom;
		@(posedge clk);
	endtask

	function automatic logic [31:0] random_arg();
		logic [7:0] ex;
		case ($urandom_range(0, 9))
			0, 1: return $urandom;
			2: return {1'($urandom), 8'h85, 7'h30, 16'($urandom)};
			3: begin
				ex = 8'($urandom_range(0, 126));
				return {1'($urandom), ex, 23'($urandom)};
			end
			default: begin
				ex = 8'($urandom_range(8'h70, 8'h85));
				return {1'($urandom), ex, 23'($urandom)};
			end
		endcase
	endfunction

	logic [31:0] directed_args[] = '{
		32'h0000_0000, 32'h8000_0000, 32'h3F80_0000, 32'hBF80_0000,
		32'h42B0_0000, 32'hC2B0_0000, 32'h42B0_0001, 32'hC2B0_0001,
		32'h42AF_FFFF, 32'hC2AF_FFFF, 32'h7F80_0000, 32'hFF80_0000,
		32'h7FC0_0000, 32'h7F80_0001, 32'hFFA5_5555, 32'h0000_0001,
		32'h8000_0001, 32'h7F7F_FFFF, 32'hFF7F_FFFF, 32'h3F31_7218,
		32'hC2AF_C000, 32'h0080_0000, 32'h3F00_0000, 32'hBF00_0000,
		32'hFFFF_FFFF
	};

	initial begin
		int idle_pct;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed_args[i])
			send_word(directed_args[i]);
		for (int phase = 0; phase < 3; phase++) begin
			idle_pct = (phase == 0) ? 10 : (phase == 1) ? 58 : 0;
			for (int i = 0; i < 450; i++) begin
				while ($urandom_range(0, 99) < idle_pct)
					idle_cycle();
				send_word(random_arg());
			end
		end
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (LATENCY + 5) @(posedge clk);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
